// ===== rtl/lfrm_pkg.sv =====
// Package for the line follow and range monitor: result kinds, register
// indexes, tracker states, line patterns, wheel speeds and range constants.
// No dependencies.
package lfrm_pkg;

  // Field widths of the sample and result channels.
  localparam int PATTERN_W = 8;
  localparam int RAW_W     = 16;
  localparam int KIND_W    = 3;
  localparam int BYTE_W    = 8;
  localparam int CFG_IDX_W = 1;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_ECHO   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FWD    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_STOP   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ISECT  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_UNSAFE = 3'd4;
  localparam logic [KIND_W-1:0] KIND_SAFE   = 3'd5;
  localparam logic [KIND_W-1:0] KIND_DIST   = 3'd6;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_LINE_ENABLE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPORT_CM   = 1'd1;

  // Line patterns with a meaning of their own.
  localparam logic [PATTERN_W-1:0] PAT_NONE   = 8'h00;
  localparam logic [PATTERN_W-1:0] PAT_EDGE_L = 8'h80;
  localparam logic [PATTERN_W-1:0] PAT_EDGE_R = 8'h01;
  localparam logic [PATTERN_W-1:0] PAT_ALL    = 8'hFF;
  localparam logic [PATTERN_W-1:0] PAT_L2     = 8'hC0;
  localparam logic [PATTERN_W-1:0] PAT_L1     = 8'h30;
  localparam logic [PATTERN_W-1:0] PAT_C      = 8'h18;
  localparam logic [PATTERN_W-1:0] PAT_R1     = 8'h0C;
  localparam logic [PATTERN_W-1:0] PAT_R2     = 8'h03;

  // Wheel speeds.
  localparam logic [BYTE_W-1:0] SPD_VEER_LO = 8'd200;
  localparam logic [BYTE_W-1:0] SPD_HARD    = 8'd201;
  localparam logic [BYTE_W-1:0] SPD_SOFT    = 8'd202;
  localparam logic [BYTE_W-1:0] SPD_CRUISE  = 8'd203;
  localparam logic [BYTE_W-1:0] SPD_VEER_HI = 8'd204;

  // Range conversion: cm = 4096 / (clamp(raw) - 10). The quotient is below
  // 64, so the divider starts from 4096 >> 6 and yields six quotient bits.
  localparam int DIST_W = 10;
  localparam int Q_W    = 6;
  localparam logic [RAW_W-1:0]  RAW_MIN    = 16'd100;
  localparam logic [RAW_W-1:0]  RAW_MAX    = 16'd830;
  localparam logic [DIST_W-1:0] RAW_OFFSET = 10'd10;
  localparam logic [DIST_W-1:0] DIV_INIT   = 10'(4096 >> Q_W);
  localparam logic [Q_W-1:0]    CM_UNSAFE  = 6'd4;

  // Tracker states.
  typedef enum logic [8:0] {
    T_NONE      = 9'b000000001,
    T_STOPPED   = 9'b000000010,
    T_OFF_LINE  = 9'b000000100,
    T_INTERSECT = 9'b000001000,
    T_L2        = 9'b000010000,
    T_L1        = 9'b000100000,
    T_C         = 9'b001000000,
    T_R1        = 9'b010000000,
    T_R2        = 9'b100000000
  } track_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_OUT  = 3'b100
  } ctrl_t;

  // One result item.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] byte_a;
    logic [BYTE_W-1:0] byte_b;
  } result_t;

endpackage

// ===== rtl/lfrm_if.sv =====
// Handshake channels of the line follow and range monitor: samples,
// results and configuration writes. Depends on lfrm_pkg.
interface lfrm_in_if;
  logic                           valid;
  logic                           ready;
  logic                           command;
  logic [lfrm_pkg::PATTERN_W-1:0] line_pattern;
  logic [lfrm_pkg::RAW_W-1:0]     range_raw;

  modport source (output valid, command, line_pattern, range_raw, input ready);
  modport sink   (input valid, command, line_pattern, range_raw, output ready);
endinterface

interface lfrm_out_if;
  logic                        valid;
  logic                        ready;
  logic [lfrm_pkg::KIND_W-1:0] kind;
  logic [lfrm_pkg::BYTE_W-1:0] byte_a;
  logic [lfrm_pkg::BYTE_W-1:0] byte_b;
  logic                        last;

  modport source (output valid, kind, byte_a, byte_b, last, input ready);
  modport sink   (input valid, kind, byte_a, byte_b, last, output ready);
endinterface

interface lfrm_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [lfrm_pkg::CFG_IDX_W-1:0] index;
  logic                           data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/line_follow_and_range_monitor_top.sv =====
// Channel    | Dir | Payload                                | Transaction
// samples    | in  | command, line_pattern, range_raw       | valid & ready
// results    | out | kind, byte_a, byte_b, last             | valid & ready
// cfg        | in  | index (0 line_enable, 1 report_cm), data | valid & ready
//
// A line sample shows one or two results while line_enable is set, and none otherwise.
// A range reading passes through the divider, which yields six quotient bits at one
// quotient bit per cycle from a shift-and-subtract loop, then one or two results.
// One sample is in flight at a time; samples.ready is low until its last
// result transaction completes. A stalled results channel holds its payload.
// Synchronous reset restores the tracker, the safe flag and both registers.
// Depends on lfrm_pkg and lfrm_if.
module line_follow_and_range_monitor_top (
  input  logic       clk,
  input  logic       rst,
  lfrm_in_if.sink    samples,
  lfrm_out_if.source results,
  lfrm_cfg_if.sink   cfg
);

  lfrm_pkg::ctrl_t   ctrl;
  lfrm_pkg::track_t  track;
  lfrm_pkg::track_t  track_next;
  logic [lfrm_pkg::PATTERN_W-1:0] prev;
  logic              safe_flag;
  logic              line_enable;
  logic              report_cm;
  logic              two_results;
  logic              slot_sel;
  logic [2:0]        step;
  lfrm_pkg::result_t slot0;
  lfrm_pkg::result_t slot1;
  logic [lfrm_pkg::DIST_W-1:0] range_val;
  logic [lfrm_pkg::DIST_W-1:0] divisor;
  logic [lfrm_pkg::DIST_W-1:0] rem;
  logic [lfrm_pkg::Q_W-1:0]    quo;

  logic in_acc;
  logic out_acc;
  logic step_last;
  logic [lfrm_pkg::PATTERN_W-1:0] pat;
  logic              line_two;
  lfrm_pkg::result_t line_res;
  logic              ex_hit;
  lfrm_pkg::track_t  ex_state;
  logic [lfrm_pkg::BYTE_W-1:0] ex_l;
  logic [lfrm_pkg::BYTE_W-1:0] ex_r;
  logic [lfrm_pkg::DIST_W-1:0] dist_clamped;
  logic [lfrm_pkg::DIST_W:0]   rem_shift;
  logic              q_bit;
  logic [lfrm_pkg::DIST_W-1:0] rem_next;
  logic [lfrm_pkg::Q_W-1:0]    cm;
  logic              evt_unsafe;
  logic              evt_safe;
  logic [lfrm_pkg::DIST_W-1:0] report_val;
  lfrm_pkg::result_t dist_res;
  lfrm_pkg::result_t cur;

  // Handshakes.
  assign samples.ready = (ctrl == lfrm_pkg::S_IDLE);
  assign cfg.ready     = 1'b1;
  assign in_acc        = samples.valid & samples.ready;
  assign out_acc       = results.valid & results.ready;
  assign step_last     = (step == 3'd0);
  assign pat           = samples.line_pattern;

  // Exact pattern lookup.
  always_comb begin
    ex_hit   = 1'b1;
    ex_state = lfrm_pkg::T_NONE;
    ex_l     = lfrm_pkg::SPD_CRUISE;
    ex_r     = lfrm_pkg::SPD_CRUISE;
    case (pat)
      lfrm_pkg::PAT_L2: begin
        ex_state = lfrm_pkg::T_L2;
        ex_l     = lfrm_pkg::SPD_HARD;
      end
      lfrm_pkg::PAT_L1: begin
        ex_state = lfrm_pkg::T_L1;
        ex_l     = lfrm_pkg::SPD_SOFT;
      end
      lfrm_pkg::PAT_C: begin
        ex_state = lfrm_pkg::T_C;
      end
      lfrm_pkg::PAT_R1: begin
        ex_state = lfrm_pkg::T_R1;
        ex_r     = lfrm_pkg::SPD_SOFT;
      end
      lfrm_pkg::PAT_R2: begin
        ex_state = lfrm_pkg::T_R2;
        ex_r     = lfrm_pkg::SPD_HARD;
      end
      default: begin
        ex_hit = 1'b0;
      end
    endcase
  end

  // Line tracker step: next state and the optional second result.
  always_comb begin
    track_next = track;
    line_two   = 1'b0;
    line_res   = '{kind: lfrm_pkg::KIND_STOP, byte_a: '0, byte_b: '0};
    if (pat == lfrm_pkg::PAT_NONE || track == lfrm_pkg::T_OFF_LINE) begin
      if (track != lfrm_pkg::T_STOPPED && track != lfrm_pkg::T_OFF_LINE) begin
        line_two = 1'b1;
        if (prev == lfrm_pkg::PAT_EDGE_L) begin
          track_next = lfrm_pkg::T_OFF_LINE;
          line_res   = '{kind: lfrm_pkg::KIND_FWD, byte_a: lfrm_pkg::SPD_VEER_LO,
                         byte_b: lfrm_pkg::SPD_VEER_HI};
        end else if (prev == lfrm_pkg::PAT_EDGE_R) begin
          track_next = lfrm_pkg::T_OFF_LINE;
          line_res   = '{kind: lfrm_pkg::KIND_FWD, byte_a: lfrm_pkg::SPD_VEER_HI,
                         byte_b: lfrm_pkg::SPD_VEER_LO};
        end else begin
          track_next = lfrm_pkg::T_STOPPED;
        end
      end else if (pat == lfrm_pkg::PAT_C) begin
        line_two   = 1'b1;
        track_next = lfrm_pkg::T_NONE;
        line_res   = '{kind: lfrm_pkg::KIND_FWD, byte_a: lfrm_pkg::SPD_CRUISE,
                       byte_b: lfrm_pkg::SPD_CRUISE};
      end
    end else if (pat == lfrm_pkg::PAT_ALL) begin
      if (track != lfrm_pkg::T_INTERSECT) begin
        line_two   = 1'b1;
        track_next = lfrm_pkg::T_INTERSECT;
        line_res   = '{kind: lfrm_pkg::KIND_ISECT, byte_a: '0, byte_b: '0};
      end
    end else if (ex_hit) begin
      if (track != ex_state) begin
        line_two   = 1'b1;
        track_next = ex_state;
        line_res   = '{kind: lfrm_pkg::KIND_FWD, byte_a: ex_l, byte_b: ex_r};
      end
    end else begin
      track_next = lfrm_pkg::T_NONE;
    end
  end

  // Range clamp to 100..830.
  always_comb begin
    if (samples.range_raw < lfrm_pkg::RAW_MIN) begin
      dist_clamped = lfrm_pkg::DIST_W'(lfrm_pkg::RAW_MIN);
    end else if (samples.range_raw > lfrm_pkg::RAW_MAX) begin
      dist_clamped = lfrm_pkg::DIST_W'(lfrm_pkg::RAW_MAX);
    end else begin
      dist_clamped = samples.range_raw[lfrm_pkg::DIST_W-1:0];
    end
  end

  // One shift-and-subtract step of the divider per cycle.
  always_comb begin
    rem_shift = {rem, 1'b0};
    q_bit     = (rem_shift >= {1'b0, divisor});
    if (q_bit) begin
      rem_next = lfrm_pkg::DIST_W'(rem_shift - {1'b0, divisor});
    end else begin
      rem_next = rem_shift[lfrm_pkg::DIST_W-1:0];
    end
  end

  // Safety events and the distance result from the finished quotient.
  always_comb begin
    cm         = {quo[lfrm_pkg::Q_W-2:0], q_bit};
    evt_unsafe = (cm == lfrm_pkg::CM_UNSAFE) && safe_flag;
    evt_safe   = (cm > lfrm_pkg::CM_UNSAFE) && !safe_flag;
    report_val = report_cm ? lfrm_pkg::DIST_W'(cm) : range_val;
    dist_res   = '{kind:   lfrm_pkg::KIND_DIST,
                   byte_a: report_val[7:0],
                   byte_b: lfrm_pkg::BYTE_W'(report_val[lfrm_pkg::DIST_W-1:8])};
  end

  // Sequencer, configuration registers and tracker state.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl        <= lfrm_pkg::S_IDLE;
      track       <= lfrm_pkg::T_NONE;
      prev        <= '0;
      safe_flag   <= 1'b1;
      line_enable <= 1'b1;
      report_cm   <= 1'b1;
      two_results <= 1'b0;
      slot_sel    <= 1'b0;
      step        <= '0;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          lfrm_pkg::REG_LINE_ENABLE: line_enable <= cfg.data;
          lfrm_pkg::REG_REPORT_CM:   report_cm   <= cfg.data;
          default: ;
        endcase
      end
      case (ctrl)
        lfrm_pkg::S_IDLE: begin
          if (in_acc) begin
            slot_sel <= 1'b0;
            if (samples.command) begin
              step <= 3'(lfrm_pkg::Q_W - 1);
              ctrl <= lfrm_pkg::S_DIV;
            end else if (line_enable) begin
              track       <= track_next;
              prev        <= pat;
              two_results <= line_two;
              ctrl        <= lfrm_pkg::S_OUT;
            end
          end
        end
        lfrm_pkg::S_DIV: begin
          step <= step - 3'd1;
          if (step_last) begin
            if (evt_unsafe) begin
              safe_flag <= 1'b0;
            end else if (evt_safe) begin
              safe_flag <= 1'b1;
            end
            two_results <= evt_unsafe | evt_safe;
            ctrl        <= lfrm_pkg::S_OUT;
          end
        end
        lfrm_pkg::S_OUT: begin
          if (out_acc) begin
            if (results.last) begin
              ctrl <= lfrm_pkg::S_IDLE;
            end else begin
              slot_sel <= 1'b1;
            end
          end
        end
        default: begin
          ctrl <= lfrm_pkg::S_IDLE;
        end
      endcase
    end
  end

  // Result slots and the divider datapath.
  always_ff @(posedge clk) begin
    if (ctrl == lfrm_pkg::S_IDLE && in_acc) begin
      slot0     <= '{kind: lfrm_pkg::KIND_ECHO, byte_a: pat, byte_b: '0};
      slot1     <= line_res;
      range_val <= dist_clamped;
      divisor   <= dist_clamped - lfrm_pkg::RAW_OFFSET;
      rem       <= lfrm_pkg::DIV_INIT;
      quo       <= '0;
    end else if (ctrl == lfrm_pkg::S_DIV) begin
      rem <= rem_next;
      quo <= cm;
      if (step_last) begin
        if (evt_unsafe) begin
          slot0 <= '{kind: lfrm_pkg::KIND_UNSAFE, byte_a: '0, byte_b: '0};
          slot1 <= dist_res;
        end else if (evt_safe) begin
          slot0 <= '{kind: lfrm_pkg::KIND_SAFE, byte_a: '0, byte_b: '0};
          slot1 <= dist_res;
        end else begin
          slot0 <= dist_res;
        end
      end
    end
  end

  // Output register view.
  assign cur            = slot_sel ? slot1 : slot0;
  assign results.valid  = (ctrl == lfrm_pkg::S_OUT);
  assign results.kind   = cur.kind;
  assign results.byte_a = cur.byte_a;
  assign results.byte_b = cur.byte_b;
  assign results.last   = slot_sel | ~two_results;

  // A sample is never taken while a result is on offer.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    samples.ready |-> !results.valid)
    else $error("sample accepted while a result is pending");

  // A range reading always goes through the divider.
  a_range_divides: assert property (@(posedge clk) disable iff (rst)
    (in_acc && samples.command) |=> (ctrl == lfrm_pkg::S_DIV))
    else $error("range reading skipped the divider");

  // The clamped range always yields at least four centimetres.
  a_cm_floor: assert property (@(posedge clk) disable iff (rst)
    (ctrl == lfrm_pkg::S_DIV && step_last) |-> (cm >= lfrm_pkg::CM_UNSAFE))
    else $error("quotient below the clamp floor");

  // Clearing the safe flag goes with a not-safe result at the head.
  a_unsafe_event: assert property (@(posedge clk) disable iff (rst)
    $fell(safe_flag) |-> (results.valid && results.kind == lfrm_pkg::KIND_UNSAFE))
    else $error("safe flag cleared without a not-safe result");

  // The last result of a sample frees the sample channel.
  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    (out_acc && results.last) |=> samples.ready)
    else $error("sample channel not freed after the last result");

endmodule
